### design/apa_sfg_pkg.sv
// Package: shared types, constants and codes for the APA102 strip frame generator.
package apa_sfg_pkg;

  localparam int MAX_LEDS_DEF  = 256;
  localparam int LED_COUNT_W   = 9;
  localparam int LED_COUNT_MAX = (1 << LED_COUNT_W) - 1;
  localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST = 9'd174;

  localparam int HEAD_LEN    = 4;   // start frame bytes
  localparam int END_MIN_LEN = 4;   // shortest end frame
  localparam int END_SHIFT   = 4;   // one end byte per 16 LEDs

  localparam logic [7:0] START_BYTE = 8'h00;
  localparam logic [7:0] END_BYTE   = 8'hFF;
  localparam logic [2:0] LED_HDR    = 3'b111;
  localparam logic [4:0] BRIGHT_MAX = 5'd31;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_REFRESH = 2'd1,
    MODE_TICK    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] brightness;
  } in_item_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic [4:0] bright;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } led_word_t;

  typedef struct packed {
    logic load_item;
    logic rd_en;
    logic start_frame;
    logic set_pending;
    logic commit_write;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       idx_ok;
    logic       frame_active;
    logic       refresh_pending;
    logic       out_busy;
  } sts_t;

endpackage

### design/apa_sfg_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module apa_sfg_ram #(
  parameter int WIDTH = 29,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/apa_sfg_ctrl.sv
// Controller: sequences accept, store lookup and commit for each input word.
module apa_sfg_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  apa_sfg_pkg::sts_t  sts,
  output apa_sfg_pkg::cmd_t  cmd
);

  apa_sfg_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= apa_sfg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      apa_sfg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = apa_sfg_pkg::ST_LOOKUP;
        end
      end
      apa_sfg_pkg::ST_LOOKUP: begin
        state_nxt = apa_sfg_pkg::ST_IDLE;
        case (sts.mode)
          apa_sfg_pkg::MODE_WRITE: begin
            if (sts.idx_ok) begin
              cmd.rd_en = 1'b1;
              state_nxt = apa_sfg_pkg::ST_COMMIT;
            end
          end
          apa_sfg_pkg::MODE_REFRESH: begin
            cmd.set_pending = 1'b1;
          end
          apa_sfg_pkg::MODE_TICK: begin
            if (sts.frame_active || sts.refresh_pending) begin
              cmd.start_frame = !sts.frame_active;
              cmd.rd_en       = 1'b1;
              state_nxt       = apa_sfg_pkg::ST_COMMIT;
            end
          end
          default: begin
            state_nxt = apa_sfg_pkg::ST_IDLE;
          end
        endcase
      end
      apa_sfg_pkg::ST_COMMIT: begin
        if (sts.mode == apa_sfg_pkg::MODE_WRITE) begin
          cmd.commit_write = 1'b1;
          state_nxt        = apa_sfg_pkg::ST_IDLE;
        end else if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = apa_sfg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = apa_sfg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### design/apa_sfg_dp.sv
// Datapath: count register, LED store, frame position and output register.
module apa_sfg_dp #(
  parameter int MAX_LEDS = apa_sfg_pkg::MAX_LEDS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [apa_sfg_pkg::LED_COUNT_W-1:0]  cfg_wdata,
  input  apa_sfg_pkg::in_item_t                in_data,
  input  apa_sfg_pkg::cmd_t                    cmd,
  output apa_sfg_pkg::sts_t                    sts,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output apa_sfg_pkg::out_item_t               out_data
);

  localparam int CNTW = apa_sfg_pkg::LED_COUNT_W;
  localparam int NMAX = (MAX_LEDS < apa_sfg_pkg::LED_COUNT_MAX) ? MAX_LEDS
                                                                 : apa_sfg_pkg::LED_COUNT_MAX;
  localparam int EMAX = ((NMAX - 1) >> apa_sfg_pkg::END_SHIFT) + 1;
  localparam int TMAX = apa_sfg_pkg::HEAD_LEN + 4 * NMAX
                      + ((EMAX > apa_sfg_pkg::END_MIN_LEN) ? EMAX : apa_sfg_pkg::END_MIN_LEN);
  localparam int PW   = $clog2(TMAX + 1);
  localparam int NW   = $clog2(NMAX + 1);
  localparam int IW   = (NW > 8) ? NW : 8;
  localparam int AW   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int LW   = PW - 2;
  localparam int WW   = $bits(apa_sfg_pkg::led_word_t);

  localparam logic [1:0] LANE_HDR   = 2'd0;
  localparam logic [1:0] LANE_BLUE  = 2'd1;
  localparam logic [1:0] LANE_GREEN = 2'd2;

  apa_sfg_pkg::in_item_t  item_r;
  logic [CNTW-1:0]        count_r, count_nxt;
  logic [PW-1:0]          pos_r, pos_nxt;
  logic                   active_r, active_nxt;
  logic                   pending_r, pending_nxt;
  logic [MAX_LEDS-1:0]    vld_r, vld_nxt;
  logic                   vld_q_r;
  logic                   out_valid_r, out_valid_nxt;
  apa_sfg_pkg::out_item_t out_data_r;

  logic [NW-1:0]          n_eff;
  logic [PW-1:0]          end_len, end_calc, body_end, total, pos_inc;
  logic                   last;
  logic [LW-1:0]          led;
  logic [AW+LW-1:0]       led_ext;
  logic [AW+7:0]          idx_ext;
  logic [AW-1:0]          led_addr, idx_addr, rd_addr;
  logic [WW-1:0]          ram_rdata;
  apa_sfg_pkg::led_word_t stored, new_word;
  logic                   differ, wr_en, count_change;
  logic [7:0]             byte_val;

  // Effective LED count and frame length.
  always_comb begin
    n_eff    = (count_r > CNTW'(NMAX)) ? NW'(NMAX) : NW'(count_r);
    end_calc = PW'((n_eff - NW'(1)) >> apa_sfg_pkg::END_SHIFT) + PW'(1);
    if (n_eff == '0 || end_calc < PW'(apa_sfg_pkg::END_MIN_LEN)) begin
      end_len = PW'(apa_sfg_pkg::END_MIN_LEN);
    end else begin
      end_len = end_calc;
    end
    body_end = PW'(apa_sfg_pkg::HEAD_LEN) + (PW'(n_eff) << 2);
    total    = body_end + end_len;
    pos_inc  = pos_r + PW'(1);
    last     = (pos_inc >= total);
  end

  // Store addressing.
  assign led      = pos_r[PW-1:2] - LW'(1);
  assign led_ext  = {{AW{1'b0}}, led};
  assign led_addr = led_ext[AW-1:0];
  assign idx_ext  = {{AW{1'b0}}, item_r.led_index};
  assign idx_addr = idx_ext[AW-1:0];
  assign rd_addr  = (item_r.mode == apa_sfg_pkg::MODE_TICK) ? led_addr : idx_addr;

  assign stored = vld_q_r ? apa_sfg_pkg::led_word_t'(ram_rdata) : '0;

  always_comb begin
    new_word.bright = (item_r.brightness > 8'(apa_sfg_pkg::BRIGHT_MAX)) ?
                      apa_sfg_pkg::BRIGHT_MAX : item_r.brightness[4:0];
    new_word.blue   = item_r.blue;
    new_word.green  = item_r.green;
    new_word.red    = item_r.red;
  end

  assign differ       = (stored != new_word);
  assign wr_en        = cmd.commit_write && differ;
  assign count_change = cfg_we && (cfg_wdata != count_r);

  apa_sfg_ram #(
    .WIDTH (WW),
    .DEPTH (MAX_LEDS)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_addr),
    .wdata (new_word),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Frame byte at the current position.
  always_comb begin
    if (pos_r < PW'(apa_sfg_pkg::HEAD_LEN)) begin
      byte_val = apa_sfg_pkg::START_BYTE;
    end else if (pos_r < body_end) begin
      case (pos_r[1:0])
        LANE_HDR:   byte_val = {apa_sfg_pkg::LED_HDR, stored.bright};
        LANE_BLUE:  byte_val = stored.blue;
        LANE_GREEN: byte_val = stored.green;
        default:    byte_val = stored.red;
      endcase
    end else begin
      byte_val = apa_sfg_pkg::END_BYTE;
    end
  end

  always_comb begin
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    active_nxt    = active_r;
    pending_nxt   = pending_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (count_change) begin
      count_nxt   = cfg_wdata;
      vld_nxt     = '0;
      pending_nxt = 1'b1;
      active_nxt  = 1'b0;
      pos_nxt     = '0;
    end else begin
      if (cmd.start_frame) begin
        pending_nxt = 1'b0;
        active_nxt  = 1'b1;
      end
      if (cmd.set_pending || wr_en) begin
        pending_nxt = 1'b1;
      end
      if (wr_en) begin
        vld_nxt[idx_addr] = 1'b1;
      end
      if (cmd.emit) begin
        out_valid_nxt = 1'b1;
        if (last) begin
          active_nxt = 1'b0;
          pos_nxt    = '0;
        end else begin
          pos_nxt = pos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= apa_sfg_pkg::LED_COUNT_RST;
      pos_r       <= '0;
      active_r    <= 1'b0;
      pending_r   <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      active_r    <= active_nxt;
      pending_r   <= pending_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.rd_en) begin
      vld_q_r <= vld_r[rd_addr];
    end
    if (cmd.emit) begin
      out_data_r.spi_byte   <= byte_val;
      out_data_r.frame_last <= last;
    end
  end

  assign sts.mode            = item_r.mode;
  assign sts.idx_ok          = (IW'(item_r.led_index) < IW'(n_eff));
  assign sts.frame_active    = active_r;
  assign sts.refresh_pending = pending_r;
  assign sts.out_busy        = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/apa102_strip_frame_generator.sv
// Top level: APA102 strip frame generator with LED colour store.
//
// Input words (in_valid/in_ready, in_data) carry a mode: write one LED's
// colour and brightness, request a refresh, or a byte-slot tick from the SPI
// shifter. Each tick while a frame is owed or running returns one frame byte
// on the output channel (out_valid/out_ready, out_data), with frame_last set
// on the final end byte. Writes, refreshes and idle ticks return nothing.
// cfg_we/cfg_wdata set the LED count; a changed count clears the store,
// aborts any frame and marks a refresh. Write it only while the block is idle.
//
// Timing: a word is accepted in the idle state, its store lookup takes the
// next cycle and its commit the one after. Only in-range writes and
// byte-emitting ticks reach commit; a tick's byte is registered there. No
// word is taken until the last is done. The rate is set by the single store
// read port: lookup, then compare or byte select on the registered read data.
// Reset (rst_n low, synchronous) returns count to 174, the store to all
// zeros, and drops any frame or pending refresh. When the receiver stalls,
// the held byte stays in the output register; a further tick waits in its
// commit step until that byte is taken, and meanwhile in_ready stays low.
module apa102_strip_frame_generator #(
  parameter int MAX_LEDS = apa_sfg_pkg::MAX_LEDS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [apa_sfg_pkg::LED_COUNT_W-1:0] cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  apa_sfg_pkg::in_item_t               in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output apa_sfg_pkg::out_item_t              out_data
);

  apa_sfg_pkg::cmd_t cmd;
  apa_sfg_pkg::sts_t sts;

  // Sequence each word through accept, lookup and commit.
  apa_sfg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the store, frame position and output byte.
  apa_sfg_dp #(
    .MAX_LEDS (MAX_LEDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

### tb/apa102_frame_checker.sv
// Checker: predicts the APA102 frame bytes from the observed words and compares them.
module apa102_frame_checker
  import apa_sfg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [LED_COUNT_W-1:0] cfg_wdata,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_data,
  output int                     owed_count,
  output int                     mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [LED_COUNT_W-1:0] strip_len;
  led_word_t              colors [MAX_LEDS_DEF];
  logic                   sending;
  logic                   owed_refresh;
  int unsigned            next_pos;
  out_item_t              bytes_owed [$];
  int                     errs = 0;

  function automatic int unsigned leds_in_use();
    return (strip_len > MAX_LEDS_DEF) ? MAX_LEDS_DEF : strip_len;
  endfunction

  function automatic void clear_colors();
    for (int i = 0; i < MAX_LEDS_DEF; i++) colors[i] = '0;
  endfunction

  // A changed count wipes the strip, drops the running frame and owes a new one.
  function automatic void load_count(input logic [LED_COUNT_W-1:0] v);
    if (v != strip_len) begin
      strip_len    = v;
      owed_refresh = 1'b1;
      sending      = 1'b0;
      next_pos     = 0;
      clear_colors();
    end
  endfunction

  // Advance the strip by one word; return 1 with the byte when a tick emits one.
  function automatic bit strip_word(input in_item_t w, output out_item_t b);
    int unsigned n, body_end, tail, total, offset;
    led_word_t   c;
    n = leds_in_use();
    b = '0;
    if (w.mode == MODE_WRITE) begin
      if (w.led_index >= n) return 1'b0;
      c.bright = (w.brightness > BRIGHT_MAX) ? BRIGHT_MAX : w.brightness[4:0];
      c.blue   = w.blue;
      c.green  = w.green;
      c.red    = w.red;
      if (colors[w.led_index] != c) begin
        colors[w.led_index] = c;
        owed_refresh = 1'b1;
      end
      return 1'b0;
    end
    if (w.mode == MODE_REFRESH) begin
      owed_refresh = 1'b1;
      return 1'b0;
    end
    if (w.mode != MODE_TICK) return 1'b0;

    if (!sending) begin
      if (!owed_refresh) return 1'b0;
      owed_refresh = 1'b0;
      sending      = 1'b1;
      next_pos     = 0;
    end
    body_end = HEAD_LEN + 4 * n;
    tail     = (n == 0) ? END_MIN_LEN : ((n - 1) >> END_SHIFT) + 1;
    if (tail < END_MIN_LEN) tail = END_MIN_LEN;
    total = body_end + tail;

    if (next_pos < HEAD_LEN) begin
      b.spi_byte = START_BYTE;
    end else if (next_pos < body_end) begin
      offset = next_pos - HEAD_LEN;
      c = colors[offset >> 2];
      case (offset % 4)
        0: b.spi_byte = {LED_HDR, c.bright};
        1: b.spi_byte = c.blue;
        2: b.spi_byte = c.green;
        default: b.spi_byte = c.red;
      endcase
    end else begin
      b.spi_byte = END_BYTE;
    end
    if (next_pos + 1 >= total) begin
      b.frame_last = 1'b1;
      sending      = 1'b0;
      next_pos     = 0;
    end else begin
      next_pos = next_pos + 1;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t fresh;
    if (!rst_n) begin
      strip_len    = LED_COUNT_RST;
      sending      = 1'b0;
      owed_refresh = 1'b0;
      next_pos     = 0;
      clear_colors();
      bytes_owed.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (bytes_owed.size() == 0) begin
          $error("spi_byte: expected none, actual %02h", out_data.spi_byte);
          errs++;
        end else begin
          want = bytes_owed.pop_front();
          if (out_data.spi_byte !== want.spi_byte) begin
            $error("spi_byte: expected %02h, actual %02h", want.spi_byte, out_data.spi_byte);
            errs++;
          end
          if (out_data.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0b, actual %0b", want.frame_last,
                   out_data.frame_last);
            errs++;
          end
        end
      end
      if (cfg_we) load_count(cfg_wdata);
      if (in_valid && in_ready) begin
        if (strip_word(in_data, fresh)) bytes_owed.push_back(fresh);
      end
    end
    owed_count     <= bytes_owed.size();
    mismatch_count <= errs;
  end

endmodule

### tb/apa102_strip_frame_generator_tb.sv
// Testbench top: drives words and LED counts into the frame generator and gives the verdict.
module apa102_strip_frame_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import apa_sfg_pkg::*;

  localparam int         CLK_PERIOD    = 8;
  localparam int         RESET_CYCLES  = 5;
  localparam int         HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int         QUIET_LIMIT   = 3000;  // cycles without any accepted word or taken byte
  localparam int         SETTLE_CYCLES = 8;     // covers a write still in its commit step
  localparam int         DRAIN_CYCLES  = 20;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [LED_COUNT_W-1:0] cfg_wdata;
  logic                   in_valid;
  logic                   in_ready;
  in_item_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_item_t              out_data;

  int       owed_count;
  int       mismatch_count;
  int       frames_seen = 0;
  bit       steady = 1'b0;        // no idling on either side while set
  bit       hold_request = 1'b0;  // ask the receiver for one long hold-off
  in_item_t last_write;

  always #(CLK_PERIOD / 2) clk = ~clk;

  apa102_strip_frame_generator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  apa102_frame_checker frame_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .owed_count     (owed_count),
    .mismatch_count (mismatch_count)
  );

  // Count finished frames so the long frame can be ticked out to its end.
  always @(posedge clk) begin
    if (out_valid && out_ready && out_data.frame_last) frames_seen <= frames_seen + 1;
  end

  // Receiver: stall about a quarter of the cycles, never while steady, and
  // hold off for a long stretch once when asked so the block backs up.
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 25);
      end
    end
  end

  // Watchdog: end the run when nothing moves on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    wait (rst_n);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  function automatic in_item_t pack_word(input logic [1:0] mode, input logic [7:0] idx,
                                         input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic [7:0] br);
    in_item_t w;
    w.mode       = mode;
    w.led_index  = idx;
    w.red        = r;
    w.green      = g;
    w.blue       = b;
    w.brightness = br;
    return w;
  endfunction

  // Mostly ticks so frames run to their end; writes mostly land within the strip or
  // just past its end so both stored and ignored writes occur, and some repeat to leave the store as is.
  function automatic in_item_t random_word(input int unsigned count);
    in_item_t    w;
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(99);
    span = (count > 255) ? 255 : count;
    w = pack_word(MODE_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    if (pick < 60) begin
      w.mode = MODE_TICK;
    end else if (pick < 85) begin
      w.mode = MODE_WRITE;
      if ($urandom_range(99) < 80) w.led_index = 8'($urandom_range(span));
      if ($urandom_range(1) == 1) w.brightness = 8'($urandom_range(BRIGHT_MAX));
      if ($urandom_range(9) == 0) w = last_write;
      last_write = w;
    end else if (pick < 94) begin
      w.mode = MODE_REFRESH;
    end else begin
      w.mode = MODE_UNUSED;
    end
    return w;
  endfunction

  // Offer one word and hold it until accepted; keep valid high for a following
  // word unless a gap is drawn.
  task automatic send_word(input in_item_t w);
    if (!steady && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Let the owed bytes drain; the checker's count is registered, so step first.
  task automatic wait_drained();
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
  endtask

  // Change the LED count only with the input quiet, nothing owed and the last
  // write past its commit step.
  task automatic set_count(input int unsigned v);
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= LED_COUNT_W'(v);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned words, input int unsigned count);
    repeat (words) send_word(random_word(count));
  endtask

  initial begin
    int start_frames;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_data    = '0;
    last_write = pack_word(MODE_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset count of 174, nothing owed: idle ticks must stay silent.
    send_word(pack_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_word(pack_word(MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // Writing the value already stored changes nothing and owes no frame.
    send_word(pack_word(MODE_WRITE, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_word(pack_word(MODE_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
    // Writes at and past the strip end are dropped.
    send_word(pack_word(MODE_WRITE, 8'd174, 8'h55, 8'h55, 8'h55, 8'd9));
    send_word(pack_word(MODE_WRITE, 8'd255, 8'hAA, 8'hAA, 8'hAA, 8'd31));
    send_word(pack_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_word(pack_word(MODE_WRITE, 8'd173, 8'hFF, 8'hFF, 8'hFF, 8'hFF));

    // Two-LED strip: saturated and zero brightness, a write past the end, then a
    // frame with a colour change and a refresh landing mid-frame.
    set_count(2);
    send_word(pack_word(MODE_WRITE, 8'd0, 8'hFF, 8'h00, 8'hAA, 8'hFF));
    send_word(pack_word(MODE_WRITE, 8'd1, 8'h01, 8'h80, 8'h7F, 8'h00));
    send_word(pack_word(MODE_WRITE, 8'd2, 8'h12, 8'h34, 8'h56, 8'd7));
    repeat (6) send_word(pack_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    send_word(pack_word(MODE_WRITE, 8'd1, 8'hC3, 8'h3C, 8'h5A, 8'd32));
    send_word(pack_word(MODE_REFRESH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
    repeat (10) send_word(pack_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));

    // Random phases over small strips, the empty strip among them.
    set_count(3);
    run_phase(30, 3);
    set_count(0);
    run_phase(30, 0);
    set_count(1);
    run_phase(30, 1);
    set_count(5);
    run_phase(30, 5);
    // Same count again: the store must survive.
    set_count(5);
    run_phase(20, 5);
    // Longer strip; stall the receiver mid-phase.
    set_count(65);
    run_phase(20, 65);
    hold_request = 1'b1;
    run_phase(40, 65);
    set_count(2);
    run_phase(20, 2);
    // No idling on either side through this phase.
    steady = 1'b1;
    set_count(17);
    run_phase(60, 17);
    steady = 1'b0;
    set_count(8);
    run_phase(20, 8);

    // Largest count, beyond the store: acts as a full strip. Tick one whole frame.
    set_count(511);
    send_word(pack_word(MODE_WRITE, 8'd255, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255))));
    send_word(pack_word(MODE_WRITE, 8'd0, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255))));
    send_word(pack_word(MODE_WRITE, 8'd128, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255))));
    start_frames = frames_seen;
    while (frames_seen == start_frames)
      send_word(pack_word(MODE_TICK, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));

    // Full strip at its exact size; the next count change cuts the frame short.
    set_count(256);
    run_phase(20, 256);
    set_count(4);
    run_phase(20, 4);

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
